[rtl/gwpf_pkg.sv]
// Package holding constants, types and helper functions of the grid wave path finder.
package gwpf_pkg;

   localparam int GRID_W = 32;
   localparam int GRID_H = 32;
   localparam int CELL_COUNT = GRID_W * GRID_H;
   localparam int CELL_BITS = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int QCNT_BITS = $clog2(CELL_COUNT + 1);
   localparam int LABEL_BITS = $clog2(CELL_COUNT + 2);
   localparam int STEP_DEPTH = 1024;
   localparam int STEP_BITS = 10;
   localparam int STEP_LIMIT = 1023;

   typedef logic [CELL_BITS-1:0] cell_type;
   typedef logic [LABEL_BITS-1:0] label_type;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_FIND = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] ST_FOUND = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_BLOCKED = 2'd2;
   localparam logic [1:0] ST_NO_PATH = 2'd3;

   localparam logic [1:0] DIR_LEFT = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP = 2'd2;
   localparam logic [1:0] DIR_DOWN = 2'd3;

   typedef enum logic [4:0] {
      S_WIPE,
      S_IDLE,
      S_RD_WALL,
      S_CHK_WALL,
      S_CLEAR,
      S_SEED,
      S_POP,
      S_POP_WAIT,
      S_NB_RD,
      S_NB_WAIT,
      S_NB_CHK,
      S_LABEL_RD,
      S_LABEL_WAIT,
      S_TR_RD,
      S_TR_WAIT,
      S_TR_CHK,
      S_TR_STORE,
      S_RESULT
   } state_type;

   function automatic logic [XW-1:0] cell_x_of(input cell_type c);
      return XW'(c % CELL_BITS'(GRID_W));
   endfunction

   function automatic logic [YW-1:0] cell_y_of(input cell_type c);
      return YW'(c / CELL_BITS'(GRID_W));
   endfunction

endpackage

[rtl/grid_wave_path_finder_core.sv]
// Top level of the grid wave path finder: wall, label, queue and step memories with a sequencer.
// Load: the wall bit is written on acceptance. Step read: the step memory output and a pending
// flag are registered, then the result. Find: the start and end wall checks, a clearing pass
// over all labels, the wave (one neighbour read-check per memory round trip), then the trace.
// One request is processed at a time; the label and wall memory ports set the rate.
// After reset a wipe pass clears the wall map; no request is taken then.
module grid_wave_path_finder_core
   import gwpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_cell_x,
   input  logic [7:0]  req_cell_y,
   input  logic        req_blocked,
   input  logic [7:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   input  logic [7:0]  req_end_x,
   input  logic [7:0]  req_end_y,
   input  logic [9:0]  req_step_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_path_len,
   output logic [1:0]  rsp_step_dir,
   output logic        rsp_step_valid
);

   logic      wall_mem [CELL_COUNT];
   label_type dist_mem [CELL_COUNT];
   cell_type  queue_mem [CELL_COUNT];
   logic [1:0] step_mem [STEP_DEPTH];

   state_type state_ff, state_in;

   logic wall_we, dist_we, queue_we, step_we;
   cell_type wall_wa, wall_ra, dist_wa, dist_ra, queue_wa;
   logic wall_wd;
   label_type dist_wd;
   cell_type queue_wd;
   logic [STEP_BITS-1:0] step_wa, step_ra;
   logic [1:0] step_wd;
   logic wall_rd_ff;
   label_type dist_rd_ff;
   cell_type queue_rd_ff;
   logic [1:0] step_rd_ff;

   cell_type cnt_ff, cnt_in;
   cell_type sc_ff, sc_in, ec_ff, ec_in;
   cell_type cur_ff, cur_in;
   cell_type nb_ff, nb_in;
   cell_type best_ff, best_in;
   label_type lab_ff, lab_in;
   label_type cur_lab_ff, cur_lab_in;
   logic [1:0] dir_ff, dir_in;
   logic [1:0] bdir_ff, bdir_in;
   logic [QCNT_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [STEP_BITS-1:0] steps_ff, steps_in, si_ff, si_in;
   logic [STEP_BITS-1:0] plen_ff, plen_in;
   logic [1:0] status_ff, status_in;
   logic rd_pend_ff, rd_pend_in;
   logic rd_ok_ff, rd_ok_in;
   logic find_ok_ff, find_ok_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic [1:0] rsp_status_ff, rsp_status_in, rsp_dir_ff, rsp_dir_in;
   logic [9:0] rsp_len_ff, rsp_len_in;
   logic rsp_sv_ff, rsp_sv_in;

   logic req_acc, out_free;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic nb_ok;
   cell_type nb_cell;
   logic [STEP_BITS:0] steps_wide;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rd_pend_ff || !out_free;
   assign req_acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (wall_we) wall_mem[wall_wa] <= wall_wd;
      wall_rd_ff <= wall_mem[wall_ra];
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd_ff <= dist_mem[dist_ra];
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      queue_rd_ff <= queue_mem[head_ff[CELL_BITS-1:0]];
      if (step_we) step_mem[step_wa] <= step_wd;
      step_rd_ff <= step_mem[step_ra];
   end

   always_comb begin
      cx = cell_x_of(cur_ff);
      cy = cell_y_of(cur_ff);
      nb_ok = 1'b0;
      nb_cell = cur_ff;
      unique case (dir_ff)
         DIR_LEFT: begin
            nb_ok = (cx != '0);
            nb_cell = cur_ff - CELL_BITS'(1);
         end
         DIR_RIGHT: begin
            nb_ok = (32'(cx) + 32'd1 < 32'(GRID_W));
            nb_cell = cur_ff + CELL_BITS'(1);
         end
         DIR_UP: begin
            nb_ok = (cy != '0);
            nb_cell = cur_ff - CELL_BITS'(GRID_W);
         end
         DIR_DOWN: begin
            nb_ok = (32'(cy) + 32'd1 < 32'(GRID_H));
            nb_cell = cur_ff + CELL_BITS'(GRID_W);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sc_in = sc_ff;
      ec_in = ec_ff;
      cur_in = cur_ff;
      nb_in = nb_ff;
      best_in = best_ff;
      lab_in = lab_ff;
      cur_lab_in = cur_lab_ff;
      dir_in = dir_ff;
      bdir_in = bdir_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      steps_in = steps_ff;
      si_in = si_ff;
      plen_in = plen_ff;
      status_in = status_ff;
      rd_pend_in = 1'b0;
      rd_ok_in = rd_ok_ff;
      find_ok_in = find_ok_ff;
      wall_we = 1'b0;
      wall_wa = cnt_ff;
      wall_wd = 1'b0;
      wall_ra = nb_cell;
      dist_we = 1'b0;
      dist_wa = cnt_ff;
      dist_wd = '0;
      dist_ra = nb_cell;
      queue_we = 1'b0;
      queue_wa = tail_ff[CELL_BITS-1:0];
      queue_wd = nb_ff;
      step_we = 1'b0;
      step_wa = si_ff;
      step_wd = bdir_ff;
      step_ra = req_step_index;
      steps_wide = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in = rsp_len_ff;
      rsp_dir_in = rsp_dir_ff;
      rsp_sv_in = rsp_sv_ff;

      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = 1'b1;
         rsp_status_in = '0;
         rsp_len_in = '0;
         rsp_dir_in = rd_ok_ff ? step_rd_ff : DIR_LEFT;
         rsp_sv_in = rd_ok_ff;
      end

      unique case (state_ff)
         S_WIPE: begin
            wall_we = 1'b1;
            wall_wa = cnt_ff;
            if (32'(cnt_ff) == CELL_COUNT - 1) begin
               state_in = S_IDLE;
            end
            cnt_in = cnt_ff + CELL_BITS'(1);
         end
         S_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  REQ_LOAD: begin
                     if (32'(req_cell_x) < GRID_W && 32'(req_cell_y) < GRID_H) begin
                        wall_we = 1'b1;
                        wall_wa = CELL_BITS'(32'(req_cell_y) * GRID_W + 32'(req_cell_x));
                        wall_wd = req_blocked;
                     end
                  end
                  REQ_FIND: begin
                     plen_in = '0;
                     if (32'(req_start_x) >= GRID_W || 32'(req_start_y) >= GRID_H ||
                         32'(req_end_x) >= GRID_W || 32'(req_end_y) >= GRID_H) begin
                        status_in = ST_RANGE;
                        state_in = S_RESULT;
                     end else begin
                        sc_in = CELL_BITS'(32'(req_start_y) * GRID_W + 32'(req_start_x));
                        ec_in = CELL_BITS'(32'(req_end_y) * GRID_W + 32'(req_end_x));
                        state_in = S_RD_WALL;
                        cnt_in = '0;
                     end
                  end
                  REQ_READ: begin
                     rd_pend_in = 1'b1;
                     rd_ok_in = req_step_index < plen_ff;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WALL: begin
            wall_ra = sc_ff;
            state_in = S_CHK_WALL;
            find_ok_in = 1'b0;
         end
         S_CHK_WALL: begin
            wall_ra = ec_ff;
            if (!find_ok_ff) begin
               find_ok_in = 1'b1;
               if (wall_rd_ff) begin
                  status_in = ST_BLOCKED;
                  state_in = S_RESULT;
               end
            end else if (wall_rd_ff) begin
               status_in = ST_BLOCKED;
               state_in = S_RESULT;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            dist_we = 1'b1;
            dist_wa = cnt_ff;
            cnt_in = cnt_ff + CELL_BITS'(1);
            if (32'(cnt_ff) == CELL_COUNT - 1) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            dist_we = 1'b1;
            dist_wa = ec_ff;
            dist_wd = LABEL_BITS'(1);
            queue_we = 1'b1;
            queue_wa = '0;
            queue_wd = ec_ff;
            head_in = '0;
            tail_in = QCNT_BITS'(1);
            state_in = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               dist_ra = sc_ff;
               state_in = S_LABEL_WAIT;
            end else begin
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cur_in = queue_rd_ff;
            dist_ra = queue_rd_ff;
            head_in = head_ff + QCNT_BITS'(1);
            dir_in = DIR_LEFT;
            state_in = S_LABEL_RD;
         end
         S_LABEL_RD: begin
            cur_lab_in = dist_rd_ff;
            state_in = S_NB_RD;
         end
         S_NB_RD: begin
            if (!nb_ok) begin
               if (dir_ff == DIR_DOWN) state_in = S_POP;
               dir_in = dir_ff + 2'd1;
            end else begin
               wall_ra = nb_cell;
               dist_ra = nb_cell;
               nb_in = nb_cell;
               state_in = S_NB_WAIT;
            end
         end
         S_NB_WAIT: begin
            state_in = S_NB_CHK;
         end
         S_NB_CHK: begin
            if (!wall_rd_ff && dist_rd_ff == '0 && 32'(tail_ff) < CELL_COUNT) begin
               dist_we = 1'b1;
               dist_wa = nb_ff;
               dist_wd = cur_lab_ff + LABEL_BITS'(1);
               queue_we = 1'b1;
               queue_wa = tail_ff[CELL_BITS-1:0];
               queue_wd = nb_ff;
               tail_in = tail_ff + QCNT_BITS'(1);
            end
            if (dir_ff == DIR_DOWN) state_in = S_POP;
            else state_in = S_NB_RD;
            dir_in = dir_ff + 2'd1;
         end
         S_LABEL_WAIT: begin
            state_in = S_TR_RD;
            lab_in = dist_rd_ff;
            cur_in = sc_ff;
            dir_in = DIR_LEFT;
            si_in = '0;
            steps_wide = STEP_BITS'(0) + (STEP_BITS+1)'(dist_rd_ff - LABEL_BITS'(1));
            if (dist_rd_ff < LABEL_BITS'(2) ||
                32'(dist_rd_ff) - 32'd1 > STEP_LIMIT) begin
               status_in = ST_NO_PATH;
               state_in = S_RESULT;
            end else begin
               steps_in = steps_wide[STEP_BITS-1:0];
               best_in = sc_ff;
               bdir_in = DIR_LEFT;
            end
         end
         S_TR_RD: begin
            if (!nb_ok) begin
               if (dir_ff == DIR_DOWN) state_in = S_TR_STORE;
               dir_in = dir_ff + 2'd1;
            end else begin
               wall_ra = nb_cell;
               dist_ra = nb_cell;
               nb_in = nb_cell;
               state_in = S_TR_WAIT;
            end
         end
         S_TR_WAIT: begin
            state_in = S_TR_CHK;
         end
         S_TR_CHK: begin
            if (!wall_rd_ff && dist_rd_ff < lab_ff) begin
               lab_in = dist_rd_ff;
               bdir_in = dir_ff;
               best_in = nb_ff;
            end
            if (dir_ff == DIR_DOWN) state_in = S_TR_STORE;
            else state_in = S_TR_RD;
            dir_in = dir_ff + 2'd1;
         end
         S_TR_STORE: begin
            step_we = 1'b1;
            step_wa = si_ff;
            step_wd = bdir_ff;
            cur_in = best_ff;
            bdir_in = DIR_LEFT;
            dir_in = DIR_LEFT;
            si_in = si_ff + STEP_BITS'(1);
            if (si_ff + STEP_BITS'(1) == steps_ff) begin
               state_in = S_RESULT;
               if (lab_ff == LABEL_BITS'(1)) begin
                  status_in = ST_FOUND;
                  plen_in = steps_ff;
               end else begin
                  status_in = ST_NO_PATH;
               end
            end else begin
               state_in = S_TR_RD;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = 1'b0;
               rsp_status_in = status_ff;
               rsp_len_in = (status_ff == ST_FOUND) ? plen_ff : '0;
               rsp_dir_in = DIR_LEFT;
               rsp_sv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
         cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plen_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         plen_ff <= plen_in;
      end
      sc_ff <= sc_in;
      ec_ff <= ec_in;
      cur_ff <= cur_in;
      nb_ff <= nb_in;
      best_ff <= best_in;
      lab_ff <= lab_in;
      cur_lab_ff <= cur_lab_in;
      dir_ff <= dir_in;
      bdir_ff <= bdir_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      steps_ff <= steps_in;
      si_ff <= si_in;
      status_ff <= status_in;
      rd_ok_ff <= rd_ok_in;
      find_ok_ff <= find_ok_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff <= rsp_len_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_sv_ff <= rsp_sv_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_path_len = rsp_len_ff;
   assign rsp_step_dir = rsp_dir_ff;
   assign rsp_step_valid = rsp_sv_ff;

   a_read_pend: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff && rsp_kind_ff)
      else $error("step read did not produce a result");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP || state_ff == S_NB_RD) |-> head_ff <= tail_ff)
      else $error("frontier queue head passed tail");
   a_len_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff |-> rsp_len_ff == '0 && rsp_status_ff == ST_FOUND)
      else $error("step read result carries find fields");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sv_ff |-> rsp_kind_ff)
      else $error("step valid set on a find result");

endmodule

[bench/tb_grid_wave_path_finder_core.sv]
// Testbench of the grid wave path finder: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_grid_wave_path_finder_core;
   import gwpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic       result_kind;
      logic [1:0] status;
      logic [9:0] path_len;
      logic [1:0] step_dir;
      logic       step_valid;
   } outcome_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_LOAD;
   logic [7:0] req_cell_x = '0, req_cell_y = '0;
   logic       req_blocked = 1'b0;
   logic [7:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic [9:0] req_step_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [1:0] rsp_status;
   logic [9:0] rsp_path_len;
   logic [1:0] rsp_step_dir;
   logic       rsp_step_valid;

   grid_wave_path_finder_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit          walls [CELL_COUNT];
   int unsigned labels [CELL_COUNT];
   logic [1:0]  route [STEP_DEPTH];
   int unsigned route_len;
   outcome_t    pending_outcomes [$];
   int          error_count = 0;
   int          outcomes_seen = 0;
   int          finds_found = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;

   function automatic bit step_to(int unsigned x, int unsigned y, int unsigned d,
                                  output int unsigned dest);
      int unsigned nx, ny;
      nx = x;
      ny = y;
      dest = 0;
      case (d)
         DIR_LEFT: begin
            if (x == 0) return 0;
            nx = x - 1;
         end
         DIR_RIGHT: begin
            if (x + 1 >= GRID_W) return 0;
            nx = x + 1;
         end
         DIR_UP: begin
            if (y == 0) return 0;
            ny = y - 1;
         end
         default: begin
            if (y + 1 >= GRID_H) return 0;
            ny = y + 1;
         end
      endcase
      dest = ny * GRID_W + nx;
      return 1;
   endfunction

   function automatic logic [1:0] route_search(int unsigned sx, int unsigned sy,
                                               int unsigned ex, int unsigned ey);
      int unsigned wave [$];
      int unsigned c, n, s, lab, steps, cur, nxt;
      logic [1:0] dir;
      route_len = 0;
      if (sx >= GRID_W || sy >= GRID_H || ex >= GRID_W || ey >= GRID_H) return ST_RANGE;
      s = sy * GRID_W + sx;
      c = ey * GRID_W + ex;
      if (walls[s] || walls[c]) return ST_BLOCKED;
      foreach (labels[i]) labels[i] = 0;
      labels[c] = 1;
      wave.push_back(c);
      while (wave.size() > 0) begin
         c = wave.pop_front();
         for (int d = 0; d < 4; d++)
            if (step_to(c % GRID_W, c / GRID_W, d, n) && !walls[n] && labels[n] == 0) begin
               labels[n] = labels[c] + 1;
               wave.push_back(n);
            end
      end
      lab = labels[s];
      if (lab < 2) return ST_NO_PATH;
      steps = lab - 1;
      if (steps > STEP_LIMIT) return ST_NO_PATH;
      cur = s;
      for (int i = 0; i < steps; i++) begin
         nxt = cur;
         dir = DIR_LEFT;
         for (int d = 0; d < 4; d++)
            if (step_to(cur % GRID_W, cur / GRID_W, d, n) && !walls[n] && labels[n] < lab) begin
               lab = labels[n];
               dir = d[1:0];
               nxt = n;
            end
         route[i] = dir;
         cur = nxt;
      end
      if (lab != 1) return ST_NO_PATH;
      route_len = steps;
      return ST_FOUND;
   endfunction

   task automatic send_request(logic [1:0] kind, logic [7:0] cx, logic [7:0] cy, logic blk,
                               logic [7:0] sx, logic [7:0] sy, logic [7:0] ex,
                               logic [7:0] ey, logic [9:0] idx);
      outcome_t o;
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clock);
      req_type = kind;
      req_cell_x = cx;
      req_cell_y = cy;
      req_blocked = blk;
      req_start_x = sx;
      req_start_y = sy;
      req_end_x = ex;
      req_end_y = ey;
      req_step_index = idx;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = '0;
      if (kind == REQ_LOAD) begin
         if (cx < GRID_W && cy < GRID_H) walls[cy * GRID_W + cx] = blk;
      end else if (kind == REQ_FIND) begin
         o.status = route_search(sx, sy, ex, ey);
         o.path_len = route_len[9:0];
         if (o.status == ST_FOUND) finds_found++;
         pending_outcomes.push_back(o);
      end else if (kind == REQ_READ) begin
         o.result_kind = 1'b1;
         o.step_valid = idx < route_len;
         o.step_dir = o.step_valid ? route[idx] : DIR_LEFT;
         pending_outcomes.push_back(o);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic load_cell(int x, int y, bit blk);
      send_request(REQ_LOAD, 8'(x), 8'(y), blk, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
   endtask

   task automatic find_route(int sx, int sy, int ex, int ey);
      send_request(REQ_FIND, 8'($urandom), 8'($urandom), 1'($urandom), 8'(sx), 8'(sy),
                   8'(ex), 8'(ey), 10'($urandom));
   endtask

   task automatic read_step(int idx);
      send_request(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 10'(idx));
   endtask

   always @(negedge clock) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      outcome_t got, want;
      if (rsp_valid && !rsp_stall) begin
         got = {rsp_result_kind, rsp_status, rsp_path_len, rsp_step_dir, rsp_step_valid};
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected kind %0d status %0d len %0d dir %0d valid %0d",
                        $time, want.result_kind, want.status, want.path_len, want.step_dir,
                        want.step_valid);
               $display("%0t:          actual kind %0d status %0d len %0d dir %0d valid %0d",
                        $time, got.result_kind, got.status, got.path_len, got.step_dir,
                        got.step_valid);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses pending", pending_outcomes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_ranges_and_walls();
      find_route(0, 0, GRID_W - 1, GRID_H - 1);
      read_step(0);
      read_step(GRID_W + GRID_H - 3);
      read_step(GRID_W + GRID_H - 2);
      read_step(1023);
      find_route(GRID_W, 0, 1, 1);
      find_route(0, 255, 1, 1);
      find_route(1, 1, 255, 0);
      find_route(1, 1, 0, GRID_H);
      load_cell(255, 255, 1);
      load_cell(GRID_W, 3, 1);
      load_cell(4, 4, 1);
      find_route(4, 4, 0, 0);
      find_route(0, 0, 4, 4);
      find_route(5, 5, 5, 5);
      load_cell(4, 4, 0);
      send_request(2'd3, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 10'h3ff);
      read_step(0);
   endtask

   task automatic test_walled_off_start();
      load_cell(1, 0, 1);
      load_cell(0, 1, 1);
      find_route(0, 0, 9, 9);
      read_step(0);
      load_cell(1, 0, 0);
      load_cell(0, 1, 0);
   endtask

   task automatic test_snake_maze();
      int x0;
      x0 = GRID_W - 8;
      for (int x = x0; x < GRID_W; x++) load_cell(x, 5, 1);
      for (int y = 0; y < 5; y++) begin
         if (y != 4) load_cell(x0 + 1, y, 1);
         if (y != 0) load_cell(x0 + 3, y, 1);
         if (y != 4) load_cell(x0 + 5, y, 1);
      end
      find_route(x0, 0, GRID_W - 1, 4);
      for (int i = 0; i < 6; i++) read_step($urandom_range(0, 24));
   endtask

   task automatic test_random_mazes(int rounds);
      int sx, sy, ex, ey;
      for (int r = 0; r < rounds; r++) begin
         repeat ($urandom_range(2, 10))
            load_cell($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 11),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 11),
                      $urandom_range(0, 2) != 0);
         sx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 11);
         sy = $urandom_range(0, 11);
         ex = $urandom_range(0, 11);
         ey = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 11);
         find_route(sx, sy, ex, ey);
         repeat ($urandom_range(1, 4))
            read_step($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 24));
         if ($urandom_range(0, 7) == 0)
            send_request(2'd3, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_ranges_and_walls();
      test_walled_off_start();
      test_snake_maze();
      test_random_mazes(7);
      calm = 1'b1;
      test_random_mazes(2);
      while (pending_outcomes.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Checked %0d responses, %0d finds with a route, over edge, wall and maze cases.",
               outcomes_seen, finds_found);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
